>>> sv/gbnp_pkg.sv
// Package for the grid bucket nearest point core: sizes, payload structs,
// command/status structs between controller and datapath. No dependencies.
package gbnp_pkg;

   localparam int TileSize     = 50;
   localparam int TilesPerSide = 10;
   localparam int SlotsPerTile = 32;
   localparam int FracBits     = 7;
   localparam int TileCount    = TilesPerSide * TilesPerSide;
   localparam int SlotCount    = TileCount * SlotsPerTile;
   localparam int TileSpan     = TileSize << FracBits;

   localparam int TileW  = $clog2(TilesPerSide);
   localparam int TileIW = $clog2(TileCount);
   localparam int SlotW  = $clog2(SlotsPerTile);
   localparam int FillW  = $clog2(SlotsPerTile + 1);
   localparam int AddrW  = $clog2(SlotCount);

   localparam logic [1:0] OpClear  = 2'd0;
   localparam logic [1:0] OpInsert = 2'd1;
   localparam logic [1:0] OpQuery  = 2'd2;

   localparam logic [1:0] StatOk    = 2'd0;
   localparam logic [1:0] StatFull  = 2'd1;
   localparam logic [1:0] StatEmpty = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [10:0] ident;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [10:0] near_id;
      logic [15:0] near_x;
      logic [15:0] near_y;
      logic [32:0] dist_sq;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic              load;      // capture request
      logic              clear;     // zero the fill count at clr_idx
      logic [TileIW-1:0] clr_idx;
      logic              insert;    // write slot, bump fill
      logic              set_tile;  // select search tile (from nb index), read its fill
      logic [3:0]        nb;        // 0 own tile, 1..8 neighbours
      logic              rd;        // read slot
      logic [SlotW-1:0]  slot;
      logic              cmp;       // compare the slot read together with rd
      logic              result;    // build response
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic             tile_ok;   // selected tile inside grid
      logic [FillW-1:0] fill;      // fill of selected tile
      logic             found;
      logic [1:0]       op;
   } stat_type;

   // tile coordinate from a 16-bit position, saturated
   function automatic logic [TileW-1:0] tile_coord(input logic [15:0] p);
      logic [TileW:0] t;
      t = '0;
      for (int i = 1; i < TilesPerSide; i++)
         if (p >= 16'(i * TileSpan)) t = (TileW+1)'(i);
      return t[TileW-1:0];
   endfunction

endpackage

>>> sv/gbnp_datapath.sv
// Datapath: fill counts, slot memory, distance unit and best-point register.
// Depends on gbnp_pkg.
module gbnp_datapath (
   input  logic               clock,
   input  logic               reset,
   input  gbnp_pkg::req_type  req,
   input  gbnp_pkg::cmd_type  cmd,
   output gbnp_pkg::stat_type stat,
   output gbnp_pkg::rsp_type  rsp
);
   localparam int TW = gbnp_pkg::TileW;

   logic [gbnp_pkg::FillW-1:0] fill_mem [gbnp_pkg::TileCount];
   logic [42:0]                mem [gbnp_pkg::SlotCount];

   gbnp_pkg::req_type req_ff;
   logic [TW-1:0] tx_ff, ty_ff;
   logic [gbnp_pkg::TileIW-1:0] tile_ff, tile_in;
   logic tok_ff, tok_in;
   logic [gbnp_pkg::FillW-1:0] fill_rd_ff;
   logic [42:0] rd_ff;
   logic [15:0] dx_ff, dy_ff;
   logic [31:0] sqx, sqy;
   logic cmpq_ff, cmp2_ff;
   logic [32:0] d_in;
   logic found_ff;
   logic [42:0] best_ff;
   logic [32:0] bestd_ff;
   gbnp_pkg::rsp_type rsp_ff, rsp_in;

   logic [TW:0] nx, ny;
   logic signed [1:0] ddx, ddy;

   always_comb begin
      case (cmd.nb)
         4'd1: begin ddx = 2'sd1;  ddy = 2'sd0;  end
         4'd2: begin ddx = 2'sd1;  ddy = 2'sd1;  end
         4'd3: begin ddx = 2'sd0;  ddy = 2'sd1;  end
         4'd4: begin ddx = -2'sd1; ddy = 2'sd1;  end
         4'd5: begin ddx = -2'sd1; ddy = 2'sd0;  end
         4'd6: begin ddx = -2'sd1; ddy = -2'sd1; end
         4'd7: begin ddx = 2'sd0;  ddy = -2'sd1; end
         4'd8: begin ddx = 2'sd1;  ddy = -2'sd1; end
         default: begin ddx = 2'sd0; ddy = 2'sd0; end
      endcase
      nx = {1'b0, tx_ff} + {{(TW-1){ddx[1]}}, ddx};
      ny = {1'b0, ty_ff} + {{(TW-1){ddy[1]}}, ddy};
      // wrap of -1 shows as all ones, beyond the grid
      tok_in = (nx < (TW+1)'(gbnp_pkg::TilesPerSide)) &&
               (ny < (TW+1)'(gbnp_pkg::TilesPerSide));
      tile_in = gbnp_pkg::TileIW'(ny[TW-1:0] * gbnp_pkg::TilesPerSide) +
                gbnp_pkg::TileIW'(nx[TW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         tx_ff  <= gbnp_pkg::tile_coord(req.pos_x);
         ty_ff  <= gbnp_pkg::tile_coord(req.pos_y);
      end
      if (cmd.set_tile)
         tile_ff <= tile_in;
      if (reset)
         tok_ff <= 1'b0;
      else if (cmd.set_tile)
         tok_ff <= tok_in;
   end

   // fill counts: one registered read per tile selection, zeroed one tile a cycle
   always_ff @(posedge clock) begin
      if (cmd.clear)
         fill_mem[cmd.clr_idx] <= '0;
      else if (cmd.insert)
         fill_mem[tile_ff] <= fill_rd_ff + 1'b1;
      if (cmd.set_tile)
         fill_rd_ff <= fill_mem[tile_in];
   end

   logic [gbnp_pkg::AddrW-1:0] wr_addr, rd_addr;
   assign wr_addr = gbnp_pkg::AddrW'(tile_ff * gbnp_pkg::SlotsPerTile) +
                    gbnp_pkg::AddrW'(fill_rd_ff);
   assign rd_addr = gbnp_pkg::AddrW'(tile_ff * gbnp_pkg::SlotsPerTile) +
                    gbnp_pkg::AddrW'(cmd.slot);

   always_ff @(posedge clock) begin
      if (cmd.insert)
         mem[wr_addr] <= {req_ff.ident, req_ff.pos_y, req_ff.pos_x};
      if (cmd.rd)
         rd_ff <= mem[rd_addr];
   end

   // distance: stage 1 differences, stage 2 squares and compare
   assign sqx  = dx_ff * dx_ff;
   assign sqy  = dy_ff * dy_ff;
   assign d_in = {1'b0, sqx} + {1'b0, sqy};
   logic [42:0] rd2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cmpq_ff  <= 1'b0;
         cmp2_ff  <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         cmpq_ff <= cmd.cmp;
         cmp2_ff <= cmpq_ff;
         if (cmd.load) found_ff <= 1'b0;
         else if (cmp2_ff && (!found_ff || d_in < bestd_ff)) found_ff <= 1'b1;
      end
      if (cmpq_ff) begin
         dx_ff  <= (rd_ff[15:0] > req_ff.pos_x) ? rd_ff[15:0] - req_ff.pos_x
                                                : req_ff.pos_x - rd_ff[15:0];
         dy_ff  <= (rd_ff[31:16] > req_ff.pos_y) ? rd_ff[31:16] - req_ff.pos_y
                                                 : req_ff.pos_y - rd_ff[31:16];
         rd2_ff <= rd_ff;
      end
      if (cmp2_ff && (!found_ff || d_in < bestd_ff)) begin
         best_ff  <= rd2_ff;
         bestd_ff <= d_in;
      end
   end

   // fill_rd_ff still holds the count from before the insert
   always_comb begin
      rsp_in = '0;
      case (req_ff.op)
         gbnp_pkg::OpInsert:
            if (fill_rd_ff >= gbnp_pkg::FillW'(gbnp_pkg::SlotsPerTile))
               rsp_in.status = gbnp_pkg::StatFull;
         gbnp_pkg::OpQuery:
            if (found_ff) begin
               rsp_in.near_id = best_ff[42:32];
               rsp_in.near_x  = best_ff[15:0];
               rsp_in.near_y  = best_ff[31:16];
               rsp_in.dist_sq = bestd_ff;
            end else
               rsp_in.status = gbnp_pkg::StatEmpty;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.result)
         rsp_ff <= rsp_in;
   end

   assign rsp          = rsp_ff;
   assign stat.tile_ok = tok_ff;
   assign stat.fill    = fill_rd_ff;
   assign stat.found   = found_ff;
   assign stat.op      = req_ff.op;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.tile_ok |-> stat.fill <= gbnp_pkg::FillW'(gbnp_pkg::SlotsPerTile))
      else $error("fill count beyond slots");
   a_found_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !found_ff) else $error("found not cleared");
   a_cmp_pipe: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp |=> cmpq_ff ##1 cmp2_ff) else $error("compare pipe broken");
endmodule

>>> sv/gbnp_ctrl.sv
// Controller: sequences clear, insert and the tile scans of a query.
// Depends on gbnp_pkg.
module gbnp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  gbnp_pkg::stat_type stat,
   output gbnp_pkg::cmd_type  cmd
);
   typedef enum logic [3:0] {
      IDLE, SEL, CHECK, CLR, SCAN, DRAIN, NEXT, RESULT, OUT
   } state_type;

   state_type state_ff;
   logic [3:0] nb_ff;
   logic [gbnp_pkg::FillW-1:0] cnt_ff;
   logic [gbnp_pkg::TileIW-1:0] clr_ff;
   logic init_ff;
   logic [1:0] drain_ff;
   logic rsp_valid_ff;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.nb       = nb_ff;
      cmd.slot     = cnt_ff[gbnp_pkg::SlotW-1:0];
      cmd.load     = (state_ff == IDLE) && req_valid;
      cmd.set_tile = (state_ff == SEL);
      cmd.clear    = (state_ff == CLR);
      cmd.clr_idx  = clr_ff;
      cmd.insert   = (state_ff == CHECK) && (stat.op == gbnp_pkg::OpInsert) &&
                     (stat.fill < gbnp_pkg::FillW'(gbnp_pkg::SlotsPerTile));
      cmd.rd       = (state_ff == SCAN) && stat.tile_ok && (cnt_ff < stat.fill);
      cmd.cmp      = cmd.rd;
      cmd.result   = (state_ff == RESULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // zero every fill count before taking the first item
         state_ff     <= CLR;
         nb_ff        <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         init_ff      <= 1'b1;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            IDLE: if (req_valid) begin
               state_ff <= SEL;
               nb_ff    <= '0;
            end
            SEL: begin
               if (stat.op == gbnp_pkg::OpQuery)
                  state_ff <= SCAN;
               else if (stat.op == gbnp_pkg::OpClear) begin
                  clr_ff   <= '0;
                  state_ff <= CLR;
               end else
                  state_ff <= CHECK;
            end
            CHECK: state_ff <= RESULT;
            CLR: begin
               if (clr_ff == gbnp_pkg::TileIW'(gbnp_pkg::TileCount - 1)) begin
                  clr_ff   <= '0;
                  init_ff  <= 1'b0;
                  state_ff <= init_ff ? IDLE : RESULT;
               end else
                  clr_ff <= clr_ff + 1'b1;
            end
            SCAN: begin
               // tile outside grid or all its filled slots read: leave it
               if (!stat.tile_ok || cnt_ff >= stat.fill) begin
                  cnt_ff   <= '0;
                  drain_ff <= 2'd3;
                  state_ff <= DRAIN;
               end else
                  cnt_ff <= cnt_ff + 1'b1;
            end
            DRAIN: begin
               if (drain_ff == 2'd0) state_ff <= NEXT;
               else drain_ff <= drain_ff - 1'b1;
            end
            NEXT: begin
               // own tile hit ends the search, else all eight neighbours are scanned
               if ((nb_ff == 4'd0 && stat.found) || nb_ff == 4'd8) state_ff <= RESULT;
               else begin
                  nb_ff    <= nb_ff + 1'b1;
                  state_ff <= SEL;
               end
            end
            RESULT: begin
               state_ff     <= OUT;
               rsp_valid_ff <= 1'b1;
            end
            OUT: if (!rsp_stall) begin
               rsp_valid_ff <= 1'b0;
               state_ff     <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_valid_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == OUT) else $error("response outside OUT");
   a_nb_range: assert property (@(posedge clock) disable iff (reset)
      nb_ff <= 4'd8) else $error("neighbour index overrun");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> req_stall) else $error("second item taken");
endmodule

>>> sv/grid_bucket_nearest_point_core.sv
// Grid bucket nearest point core. Depends on gbnp_pkg, gbnp_ctrl, gbnp_datapath.
// One item at a time. Insert and unused op: states SEL, CHECK and RESULT, then the
// response is held in OUT until taken. Clear: one tile zeroed a cycle, then RESULT.
// Query: each tile is selected, its filled slots are read and compared, then drained;
// own tile first, then all eight neighbours when it is empty; outside tiles are skipped.
// Synchronous active-high reset, then a fill clearing pass with req_stall high.
module grid_bucket_nearest_point_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbnp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbnp_pkg::rsp_type rsp_data
);
   gbnp_pkg::cmd_type  cmd;
   gbnp_pkg::stat_type stat;

   gbnp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd
   );

   gbnp_datapath u_dp (
      .clock, .reset, .req(req_data), .cmd, .stat, .rsp(rsp_data)
   );
endmodule
